FILE: hdl/scor_pkg.sv
// types and constants for the shift chain output refresher
// no dependencies; imported by every module of the block
package scor_pkg;

	// fixed field widths
	localparam int FIELD_BITS    = 32;
	localparam int HOLD_BITS     = 16;
	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_RESET_HOLD_TICKS = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_PATTERN  = 4'd1;

	// configuration reset values
	localparam logic [HOLD_BITS-1:0]     RESET_HOLD_TICKS_INIT = 16'd100;
	localparam logic [CFG_DATA_BITS-1:0] DEFAULT_PATTERN_INIT  = 32'hFFFF_FFFF;

	// tick word
	typedef struct packed {
		logic [FIELD_BITS-1:0] high_word;
		logic [FIELD_BITS-1:0] low_word;
	} tick_word_t;

	// serial chain word
	typedef struct packed {
		logic serial_bit;
		logic latch_after;
	} chain_word_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_hold;
		logic load_new;
		logic shift;
	} scor_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hold_active;
		logic changed;
		logic last_bit;
	} scor_status_t;

endpackage

FILE: hdl/scor_ctrl.sv
// controller state machine for the shift chain output refresher
// depends on scor_pkg; drives handshakes and datapath commands
module scor_ctrl
	import scor_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         tick_valid,
	output logic         tick_ready,
	output logic         chain_valid,
	input  logic         chain_ready,
	input  scor_status_t status,
	output scor_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_DECIDE = 3'b010,
		S_SHIFT  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		tick_ready    = 1'b0;
		chain_valid   = 1'b0;
		case (state_q)
			S_IDLE: begin
				tick_ready  = 1'b1;
				cmd.capture = tick_valid;
				if (tick_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.load_hold = status.hold_active;
				cmd.load_new  = !status.hold_active && status.changed;
				if (status.hold_active || status.changed) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				chain_valid = 1'b1;
				cmd.shift   = chain_ready;
				if (chain_ready && status.last_bit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/scor_dp.sv
// datapath: config registers, hold counter, sent copies, chain shifter
// depends on scor_pkg; commanded by scor_ctrl
module scor_dp
	import scor_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  tick_word_t               tick_data,
	output chain_word_t              chain_data,
	input  scor_cmd_t                cmd,
	output scor_status_t             status
);

	localparam int CHAIN_BITS = 2 * WORD_BITS;
	localparam int CNT_BITS   = $clog2(CHAIN_BITS);
	localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(CHAIN_BITS - 1);

	logic [HOLD_BITS-1:0]  hold_ticks_q;
	logic [WORD_BITS-1:0]  pattern_q;
	logic [HOLD_BITS-1:0]  hold_count_q;
	logic [WORD_BITS-1:0]  sent_high_q;
	logic [WORD_BITS-1:0]  sent_low_q;
	logic [WORD_BITS-1:0]  high_q;
	logic [WORD_BITS-1:0]  low_q;
	logic [CHAIN_BITS-1:0] shift_q;
	logic [CNT_BITS-1:0]   cnt_q;

	// configuration registers, only the used low bits of the pattern are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= RESET_HOLD_TICKS_INIT;
			pattern_q    <= DEFAULT_PATTERN_INIT[WORD_BITS-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_BITS-1:0];
				REG_DEFAULT_PATTERN:  pattern_q    <= cfg_data[WORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// captured tick words
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			high_q <= tick_data.high_word[WORD_BITS-1:0];
			low_q  <= tick_data.low_word[WORD_BITS-1:0];
		end
	end

	// hold counter and sent copies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q <= '0;
			sent_high_q  <= '0;
			sent_low_q   <= '0;
		end else begin
			if (cmd.load_hold) begin
				hold_count_q <= hold_count_q + HOLD_BITS'(1);
			end
			if (cmd.load_new) begin
				sent_high_q <= high_q;
				sent_low_q  <= low_q;
			end
		end
	end

	// chain shifter, msb goes out first
	always_ff @(posedge clk) begin
		if (cmd.load_hold) begin
			shift_q <= {pattern_q, pattern_q};
		end else if (cmd.load_new) begin
			shift_q <= {high_q, low_q};
		end else if (cmd.shift) begin
			shift_q <= {shift_q[CHAIN_BITS-2:0], 1'b0};
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_hold || cmd.load_new) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	// status and output word
	always_comb begin
		status.hold_active     = hold_count_q < hold_ticks_q;
		status.changed         = (high_q != sent_high_q) || (low_q != sent_low_q);
		status.last_bit        = cnt_q == LAST_CNT;
		chain_data.serial_bit  = shift_q[CHAIN_BITS-1];
		chain_data.latch_after = cnt_q == LAST_CNT;
	end

endmodule

FILE: hdl/shift_chain_output_refresher.sv
// top level of the shift chain output refresher
// depends on scor_pkg, scor_ctrl and scor_dp
//
// channel   direction  handshake                 word
// tick      in         tick_valid / tick_ready   tick_data   (high_word, low_word)
// chain     out        chain_valid / chain_ready chain_data  (serial_bit, latch_after)
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// a tick is captured in idle and judged in decide; a refresh then shifts
// 2*WORD_BITS bits from the chain shifter, one per cycle while chain_ready is high
// a tick after the hold whose words match the sent copies sends nothing
// reset restores the config defaults and clears the hold count and sent copies
// a stalled chain_ready holds the current bit; no tick is taken during a burst
module shift_chain_output_refresher
	import scor_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     tick_valid,
	output logic                     tick_ready,
	input  tick_word_t               tick_data,
	output logic                     chain_valid,
	input  logic                     chain_ready,
	output chain_word_t              chain_data
);

	scor_cmd_t    cmd;
	scor_status_t status;

	// control
	scor_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_ready  (tick_ready),
		.chain_valid (chain_valid),
		.chain_ready (chain_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// datapath
	scor_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_data  (tick_data),
		.chain_data (chain_data),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

FILE: test/tb_top.sv
// self-checking testbench for shift_chain_output_refresher
// depends on scor_pkg and the block's rtl; a directed plan runs first, then random phases
// every accepted chain word is checked against the plan's expected words or a predictor of the hold and change logic
module tb_top;
	import scor_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHAIN_HALF = 32;
	localparam logic [31:0] HALF_MASK = 32'((64'd1 << CHAIN_HALF) - 64'd1);
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 17;
	localparam int CALM_FIRST = 50;
	localparam int CALM_LAST = 80;
	localparam int HOLDOFF_START = 4000;
	localparam int HOLDOFF_LEN = 400;
	localparam int RX_CALM_START = 7000;
	localparam int RX_CALM_END = 10000;

	typedef enum logic [1:0] {ROW_TICK, ROW_HOLD_LEN, ROW_PATTERN} row_kind_t;

	// one plan row: a tick, or a register value carried in hi
	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] hi;
		logic [31:0] lo;
		logic        typed;
		logic        fire;
		logic [31:0] e_hi;
		logic [31:0] e_lo;
	} plan_row_t;

	localparam int PLAN_ROWS = 27;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// hold with reset defaults: all ones whatever the tick carries
		'{ROW_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{ROW_TICK, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{ROW_PATTERN, 32'hA5A5_0F0F, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_0F0F, 32'hA5A5_0F0F},
		// lowering the hold length ends the hold at once
		'{ROW_HOLD_LEN, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		// sent copies are still zero, so zero words send nothing
		'{ROW_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{ROW_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000},
		'{ROW_TICK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
		'{ROW_TICK, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1, 32'h8000_0000, 32'h0000_0001},
		'{ROW_TICK, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0001, 32'h8000_0000},
		'{ROW_TICK, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 32'h0},
		// raising the hold length past the count reopens the hold
		'{ROW_HOLD_LEN, 32'h0000_0005, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_PATTERN, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000},
		'{ROW_TICK, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000},
		// hold over; copies were not touched by the hold ticks
		'{ROW_TICK, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_PATTERN, 32'h5555_AAAA, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_HOLD_LEN, 32'h0000_FFFF, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'h1357_9BDF, 32'h2468_ACE0, 1'b1, 1'b1, 32'h5555_AAAA, 32'h5555_AAAA},
		'{ROW_HOLD_LEN, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000},
		'{ROW_TICK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_TICK, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0, 32'h0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic tick_valid = 1'b0;
	logic tick_ready;
	tick_word_t tick_data = '0;
	logic chain_valid;
	logic chain_ready = 1'b0;
	chain_word_t chain_data;

	// predictor state and its copy of the registers
	logic [HOLD_BITS-1:0] hold_done;
	logic [31:0] sent_hi;
	logic [31:0] sent_lo;
	logic [HOLD_BITS-1:0] hold_len;
	logic [31:0] pattern;

	chain_word_t pending_bits [$];
	int mismatches = 0;
	int cycle_count = 0;
	int rx_cycle = 0;

	shift_chain_output_refresher #(
		.WORD_BITS(CHAIN_HALF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.tick_data(tick_data),
		.chain_valid(chain_valid),
		.chain_ready(chain_ready),
		.chain_data(chain_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hold decision, then change test against the sent copies
	function automatic void refresh_decision(input tick_word_t w, output bit fire,
			output logic [31:0] out_hi, output logic [31:0] out_lo);
		logic [31:0] hi;
		logic [31:0] lo;
		hi = w.high_word & HALF_MASK;
		lo = w.low_word & HALF_MASK;
		fire = 1'b0;
		out_hi = '0;
		out_lo = '0;
		if (hold_done < hold_len) begin
			hold_done = hold_done + 1'b1;
			fire = 1'b1;
			out_hi = pattern & HALF_MASK;
			out_lo = pattern & HALF_MASK;
		end else if (hi != sent_hi || lo != sent_lo) begin
			sent_hi = hi;
			sent_lo = lo;
			fire = 1'b1;
			out_hi = hi;
			out_lo = lo;
		end
	endfunction

	// one burst: high word msb first, then low word, latch on the last bit
	function automatic void queue_burst(input logic [31:0] hi, input logic [31:0] lo);
		chain_word_t e;
		for (int i = CHAIN_HALF - 1; i >= 0; i--) begin
			e.serial_bit = hi[i];
			e.latch_after = 1'b0;
			pending_bits.push_back(e);
		end
		for (int i = CHAIN_HALF - 1; i >= 0; i--) begin
			e.serial_bit = lo[i];
			e.latch_after = (i == 0);
			pending_bits.push_back(e);
		end
	endfunction

	// random tick, mostly repeats and near misses of the sent copies
	function automatic tick_word_t next_tick();
		tick_word_t w;
		int r;
		logic [31:0] corners [4];
		corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
		r = $urandom_range(0, 99);
		w.high_word = sent_hi;
		w.low_word = sent_lo;
		if (r < 35) begin
			// unchanged words
		end else if (r < 55) begin
			w = tick_word_t'(w ^ (64'd1 << $urandom_range(0, 63)));
		end else if (r < 65) begin
			w.high_word = corners[$urandom_range(0, 3)];
			w.low_word = corners[$urandom_range(0, 3)];
		end else begin
			w.high_word = $urandom;
			w.low_word = $urandom;
		end
		return w;
	endfunction

	// offer one tick word and record what it should cause
	task automatic send_tick(input tick_word_t w, input bit typed, input bit t_fire,
			input logic [31:0] t_hi, input logic [31:0] t_lo, input bit calm);
		int gap;
		bit fire;
		logic [31:0] p_hi;
		logic [31:0] p_lo;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 38) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_data <= w;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
		refresh_decision(w, fire, p_hi, p_lo);
		if (typed) begin
			fire = t_fire;
			p_hi = t_hi;
			p_lo = t_lo;
		end
		if (fire) queue_burst(p_hi, p_lo);
	endtask

	// wait until the chain has drained and the block has gone idle
	task automatic settle();
		tick_valid <= 1'b0;
		while (pending_bits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RESET_HOLD_TICKS: hold_len = value[HOLD_BITS-1:0];
			REG_DEFAULT_PATTERN: pattern = value;
			default: ;
		endcase
	endtask

	// stimulus: reset, directed plan, random phases, drain
	initial begin
		tick_word_t w;
		logic [HOLD_BITS-1:0] len;
		logic [31:0] pat;
		int item;
		hold_done = '0;
		sent_hi = '0;
		sent_lo = '0;
		hold_len = RESET_HOLD_TICKS_INIT;
		pattern = DEFAULT_PATTERN_INIT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			case (PLAN[i].kind)
				ROW_HOLD_LEN: begin
					settle();
					write_reg(REG_RESET_HOLD_TICKS, PLAN[i].hi);
				end
				ROW_PATTERN: begin
					settle();
					write_reg(REG_DEFAULT_PATTERN, PLAN[i].hi);
				end
				default: begin
					w.high_word = PLAN[i].hi;
					w.low_word = PLAN[i].lo;
					send_tick(w, PLAN[i].typed, PLAN[i].fire, PLAN[i].e_hi, PLAN[i].e_lo, 1'b0);
				end
			endcase
		end

		item = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin len = '0; pat = $urandom; end
				1: begin len = hold_done + 16'($urandom_range(2, 4)); pat = 32'h0; end
				2: begin len = 16'hFFFF; pat = 32'hFFFF_FFFF; end
				3: begin len = '0; pat = 32'h8000_0001; end
				4: begin len = hold_done + 16'($urandom_range(1, 3)); pat = $urandom; end
				default: begin len = '0; pat = $urandom; end
			endcase
			write_reg(REG_RESET_HOLD_TICKS, CFG_DATA_BITS'(len));
			write_reg(REG_DEFAULT_PATTERN, pat);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				w = next_tick();
				send_tick(w, 1'b0, 1'b0, 32'h0, 32'h0, item >= CALM_FIRST && item < CALM_LAST);
				item++;
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// receiver: random stalls, one long hold-off, one stretch always ready
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle >= HOLDOFF_START && rx_cycle < HOLDOFF_START + HOLDOFF_LEN) begin
			chain_ready <= 1'b0;
		end else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_END) begin
			chain_ready <= 1'b1;
		end else begin
			chain_ready <= ($urandom_range(0, 99) >= 38);
		end
	end

	// compare each accepted chain word with the oldest pending bit
	always @(posedge clk) begin : chain_check
		chain_word_t want;
		if (arst_n && chain_valid && chain_ready) begin
			if (pending_bits.size() == 0) begin
				$display("%0t: chain word expected none actual %b", $time, chain_data);
				mismatches++;
			end else begin
				want = pending_bits.pop_front();
				if (chain_data.serial_bit !== want.serial_bit) begin
					$display("%0t: serial_bit expected %b actual %b",
						$time, want.serial_bit, chain_data.serial_bit);
					mismatches++;
				end
				if (chain_data.latch_after !== want.latch_after) begin
					$display("%0t: latch_after expected %b actual %b",
						$time, want.latch_after, chain_data.latch_after);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d chain words still pending", $time, pending_bits.size());
			$display("tb_top failed");
			$finish;
		end
	end

endmodule

FILE: filelist.f
hdl/scor_pkg.sv
hdl/scor_ctrl.sv
hdl/scor_dp.sv
hdl/shift_chain_output_refresher.sv
test/tb_top.sv
